[rtl/core/table_driven_fsm_engine_top_assert.svh]
// assertion macros for the table driven fsm engine
// used by table_driven_fsm_engine_top, expects clk and arst_n in scope
`ifndef TABLE_DRIVEN_FSM_ENGINE_TOP_ASSERT_SVH
`define TABLE_DRIVEN_FSM_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TDFE_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define TDFE_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define TDFE_ASSERT_IMP(lbl, pre, post)
`define TDFE_ASSERT_NXT(lbl, pre, post)
`endif
`endif

[rtl/core/tdfe_pkg.sv]
// shared types and constants of the table driven fsm engine
// no dependencies
`timescale 1ns / 1ps
package tdfe_pkg;
	typedef struct packed {
		logic [2:0]         action;
		logic [3:0]         word_index;
		logic signed [15:0] word_value;
		logic [4:0]         evt_no;
	} tdfe_in_t;

	typedef struct packed {
		logic               packet_accepted;
		logic               load_done;
		logic               start_pressed;
		logic [6:0]         current_index;
		logic signed [15:0] rec_state_no;
		logic signed [15:0] rec_action_no;
		logic signed [15:0] rec_value0;
		logic signed [15:0] rec_value1;
		logic signed [15:0] rec_value2;
		logic signed [15:0] rec_value3;
	} tdfe_out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SCAN,
		S_DRAIN,
		S_APPLY,
		S_REC,
		S_OUT
	} tdfe_state_t;

	localparam logic [2:0] ACT_WORD  = 3'd0;
	localparam logic [2:0] ACT_EVENT = 3'd1;
	localparam logic [2:0] ACT_STEP  = 3'd2;
	localparam logic [2:0] ACT_INIT  = 3'd3;

	localparam logic [15:0] TYPE_COUNTS  = 16'd1;
	localparam logic [15:0] TYPE_TABLE   = 16'd2;
	localparam logic [15:0] TYPE_RECORDS = 16'd3;
	localparam logic [15:0] TYPE_START   = 16'd254;
	localparam logic [15:0] TYPE_FINISH  = 16'd255;

	localparam logic [3:0] IDX_SEQ   = 4'd0;
	localparam logic [3:0] IDX_TYPE  = 4'd1;
	localparam logic [3:0] IDX_SCNT  = 4'd2;
	localparam logic [3:0] IDX_ECNT  = 4'd3;
	localparam logic [3:0] IDX_LAST  = 4'd15;

	localparam logic [7:0] NO_TRANS  = 8'hFF;
	localparam logic [2:0] REC_WORDS = 3'd6;
	localparam int         ADDR_W    = 17;
endpackage

[rtl/core/tdfe_ram.sv]
// simple dual port ram with registered read, used for table and record stores
// depends on nothing
`timescale 1ns / 1ps
module tdfe_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

[rtl/core/table_driven_fsm_engine_top.sv]
// top level of the table driven fsm engine: sequencer, registers, two stores
// depends on tdfe_pkg, tdfe_ram and table_driven_fsm_engine_top_assert.svh
`timescale 1ns / 1ps
// usage
// - req channel (req_valid/req_ready/req_word) carries one command word:
//   packet word, set event, step, reinitialize or query
// - rsp channel (rsp_valid/rsp_ready/rsp_word) returns exactly one word per
//   command: end-of-packet flags, current state and its six-word record
// - req_ready is high only while the sequencer is idle; one word at a time
// - non-step commands go straight to the record readout: six record reads
//   through the one record port, then the response is loaded for output
// - step: one multiply for the row base, then the table address counter
//   walks the event flags, reading the table for each set flag at most one
//   table read per cycle, then the record reads
// - reset and reinitialize clear counters, pointers, flags and latches; store
//   entries at or past a write pointer read as zero, so no sweep is needed
// - a pending response sits in the output register while the next command
//   is taken; if rsp_ready stays low the new response waits in S_OUT and
//   req_ready stays low until the old one is taken
module table_driven_fsm_engine_top #(
	parameter int TRANS_DEPTH  = 4096,
	parameter int RECORD_DEPTH = 1024,
	parameter int MAX_EVENTS   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  tdfe_pkg::tdfe_in_t  req_word,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output tdfe_pkg::tdfe_out_t rsp_word
);
	import tdfe_pkg::*;
	`include "table_driven_fsm_engine_top_assert.svh"

	localparam int TAW = (TRANS_DEPTH > 1) ? $clog2(TRANS_DEPTH) : 1;
	localparam int RAW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
	localparam int TPW = $clog2(TRANS_DEPTH + 1);
	localparam int RPW = $clog2(RECORD_DEPTH + 1);
	localparam int EW  = $clog2(MAX_EVENTS + 1);
	localparam logic [ADDR_W-1:0] TRANS_LIM = ADDR_W'(TRANS_DEPTH);

	tdfe_state_t state_q, state_d;

	// loader and machine state
	logic [15:0]           seq_cnt_q;
	logic [TPW-1:0]        tptr_q;
	logic [RPW-1:0]        rptr_q;
	logic [EW-1:0]         evt_cnt_q;
	logic [6:0]            cur_q;
	logic [MAX_EVENTS-1:0] flags_q;
	logic [15:0]           seq_lat_q;
	logic [15:0]           type_lat_q;
	logic                  f_acc_q, f_done_q, f_start_q;

	// scan unit
	logic [ADDR_W-1:0]     tab_addr_q;
	logic [EW-1:0]         scan_i_q;
	logic                  ttag_q, tfill_q, hit_q;
	logic [7:0]            next_q;

	// record readout
	logic [2:0]            rk_q, rcap_q;
	logic                  rpend_q, rtag_q;
	logic [15:0]           rbuf_q [6];

	logic                  rsp_valid_q;
	tdfe_out_t             rsp_q;

	// command decode
	logic        acc;
	logic [15:0] w;
	logic        matched, data_word;
	logic        tab_we, rec_we, tab_re, rec_re;
	logic        end_acc, end_done, end_start;
	logic [7:0]  tab_rdata, tab_val;
	logic [15:0] rec_rdata;
	logic [MAX_EVENTS-1:0] flags_sh, flags_set;
	logic        flag_bit, scan_more, rin, rsp_load;
	logic [ADDR_W-1:0] rec_addr;
	logic [EW-1:0] evt_clamp;

	assign req_ready = (state_q == S_IDLE);
	assign acc       = req_valid && req_ready;
	assign w         = req_word.word_value;
	assign matched   = (seq_lat_q == seq_cnt_q);
	assign data_word = acc && (req_word.action == ACT_WORD)
		&& (req_word.word_index != IDX_SEQ) && (req_word.word_index != IDX_TYPE);

	// appends, dropped once a store is full
	assign tab_we = data_word && matched && (type_lat_q == TYPE_TABLE)
		&& (tptr_q < TPW'(TRANS_DEPTH));
	assign rec_we = data_word && matched && (type_lat_q == TYPE_RECORDS)
		&& (rptr_q < RPW'(RECORD_DEPTH));

	// end of packet outcomes, in priority order
	assign end_acc   = data_word && (req_word.word_index == IDX_LAST) && matched
		&& (type_lat_q >= TYPE_COUNTS) && (type_lat_q <= TYPE_RECORDS);
	assign end_done  = data_word && (req_word.word_index == IDX_LAST) && !end_acc
		&& (type_lat_q == TYPE_FINISH);
	assign end_start = data_word && (req_word.word_index == IDX_LAST) && !end_acc
		&& (type_lat_q == TYPE_START);

	// negative count is zero, large one saturates
	assign evt_clamp = w[15] ? '0 :
		((w > 16'(MAX_EVENTS)) ? EW'(MAX_EVENTS) : w[EW-1:0]);

	always_comb begin
		for (int j = 0; j < MAX_EVENTS; j++) begin
			flags_set[j] = (32'(req_word.evt_no) == j);
		end
	end

	assign flags_sh  = flags_q >> scan_i_q;
	assign flag_bit  = flags_sh[0];
	assign scan_more = (scan_i_q != evt_cnt_q);

	// table entries past the fill pointer read as zero
	assign tab_val = tfill_q ? tab_rdata : 8'd0;

	// record address: cur*6 + k; words past the fill pointer read as zero
	assign rec_addr = (ADDR_W'(cur_q) << 2) + (ADDR_W'(cur_q) << 1) + ADDR_W'(rk_q);
	assign rin      = (rec_addr < ADDR_W'(rptr_q));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		tab_re   = 1'b0;
		rec_re   = 1'b0;
		rsp_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					state_d = (req_word.action == ACT_STEP) ? S_MUL : S_REC;
				end
			end
			S_MUL: begin
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (scan_more) begin
					tab_re = flag_bit && (tab_addr_q < TRANS_LIM);
				end else begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_APPLY;
			end
			S_APPLY: begin
				state_d = S_REC;
			end
			S_REC: begin
				if (rk_q != REC_WORDS) begin
					rec_re = rin;
				end else begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_cnt_q   <= 16'd1;
			tptr_q      <= '0;
			rptr_q      <= '0;
			evt_cnt_q   <= '0;
			cur_q       <= '0;
			flags_q     <= '0;
			seq_lat_q   <= '0;
			type_lat_q  <= '0;
			f_acc_q     <= 1'b0;
			f_done_q    <= 1'b0;
			f_start_q   <= 1'b0;
			tab_addr_q  <= '0;
			scan_i_q    <= '0;
			ttag_q      <= 1'b0;
			tfill_q     <= 1'b0;
			hit_q       <= 1'b0;
			rk_q        <= '0;
			rpend_q     <= 1'b0;
			rtag_q      <= 1'b0;
			rcap_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				f_acc_q   <= end_acc;
				f_done_q  <= end_done;
				f_start_q <= end_start;
				unique case (req_word.action)
					ACT_WORD: begin
						if (req_word.word_index == IDX_SEQ) begin
							seq_lat_q <= w;
						end else if (req_word.word_index == IDX_TYPE) begin
							type_lat_q <= w;
						end else if (matched && type_lat_q == TYPE_COUNTS
							&& req_word.word_index == IDX_ECNT) begin
							evt_cnt_q <= evt_clamp;
						end
						if (tab_we) begin
							tptr_q <= tptr_q + 1'b1;
						end
						if (rec_we) begin
							rptr_q <= rptr_q + 1'b1;
						end
						if (end_acc) begin
							seq_cnt_q <= seq_cnt_q + 16'd1;
						end
						if (end_done) begin
							cur_q   <= '0;
							flags_q <= '0;
						end
					end
					ACT_EVENT: begin
						flags_q <= flags_q | flags_set;
					end
					ACT_INIT: begin
						seq_cnt_q  <= 16'd1;
						tptr_q     <= '0;
						rptr_q     <= '0;
						evt_cnt_q  <= '0;
						cur_q      <= '0;
						flags_q    <= '0;
						seq_lat_q  <= '0;
						type_lat_q <= '0;
					end
					default: begin
					end
				endcase
			end

			// row base, one multiply
			if (state_q == S_MUL) begin
				tab_addr_q <= ADDR_W'(cur_q) * ADDR_W'(evt_cnt_q);
				scan_i_q   <= '0;
				hit_q      <= 1'b0;
			end
			if (state_q == S_SCAN && scan_more) begin
				tab_addr_q <= tab_addr_q + 1'b1;
				scan_i_q   <= scan_i_q + 1'b1;
			end
			ttag_q  <= tab_re;
			tfill_q <= (tab_addr_q < ADDR_W'(tptr_q));
			// last valid entry wins
			if (ttag_q && tab_val != NO_TRANS) begin
				hit_q  <= 1'b1;
				next_q <= tab_val;
			end
			if (state_q == S_APPLY) begin
				if (hit_q) begin
					cur_q <= next_q[6:0];
				end
				flags_q <= '0;
			end

			// record words, one read a cycle, captured in the following cycle
			if (state_q == S_REC && rk_q != REC_WORDS) begin
				rk_q <= rk_q + 3'd1;
			end else if (state_q != S_REC) begin
				rk_q <= '0;
			end
			rpend_q <= (state_q == S_REC) && (rk_q != REC_WORDS);
			rtag_q  <= rec_re;
			rcap_q  <= rk_q;

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rpend_q) begin
			rbuf_q[rcap_q] <= rtag_q ? rec_rdata : 16'd0;
		end
		if (rsp_load) begin
			rsp_q.packet_accepted <= f_acc_q;
			rsp_q.load_done       <= f_done_q;
			rsp_q.start_pressed   <= f_start_q;
			rsp_q.current_index   <= cur_q;
			rsp_q.rec_state_no    <= rbuf_q[0];
			rsp_q.rec_action_no   <= rbuf_q[1];
			rsp_q.rec_value0      <= rbuf_q[2];
			rsp_q.rec_value1      <= rbuf_q[3];
			rsp_q.rec_value2      <= rbuf_q[4];
			rsp_q.rec_value3      <= rbuf_q[5];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	tdfe_ram #(
		.DEPTH(TRANS_DEPTH),
		.WIDTH(8)
	) u_trans_ram (
		.clk  (clk),
		.we   (tab_we),
		.waddr(tptr_q[TAW-1:0]),
		.wdata(w[7:0]),
		.re   (tab_re),
		.raddr(tab_addr_q[TAW-1:0]),
		.rdata(tab_rdata)
	);

	tdfe_ram #(
		.DEPTH(RECORD_DEPTH),
		.WIDTH(16)
	) u_rec_ram (
		.clk  (clk),
		.we   (rec_we),
		.waddr(rptr_q[RAW-1:0]),
		.wdata(w),
		.re   (rec_re),
		.raddr(rec_addr[RAW-1:0]),
		.rdata(rec_rdata)
	);

	// checks
	`TDFE_ASSERT_IMP(a_scan_bound, state_q == S_SCAN, scan_i_q <= evt_cnt_q)
	`TDFE_ASSERT_IMP(a_tab_rd_range, tab_re, tab_addr_q < TRANS_LIM)
	`TDFE_ASSERT_NXT(a_busy_after_acc, req_valid && req_ready, !req_ready)
	`TDFE_ASSERT_IMP(a_rec_rd_phase, rec_re, state_q == S_REC && rk_q < REC_WORDS)
endmodule

[dv/tdfe_checker.sv]
// response checker for the table driven fsm engine: predicts every response word
// from the accepted command words and compares it with the word that comes back
// depends on tdfe_pkg
`timescale 1ns / 1ps
module tdfe_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_ready,
	input  tdfe_pkg::tdfe_in_t  req_word,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  tdfe_pkg::tdfe_out_t rsp_word,
	output int                  errors,
	output int                  pending
);
	import tdfe_pkg::*;

	localparam int TRANS_SLOTS  = 4096;
	localparam int RECORD_SLOTS = 1024;
	localparam int EVENT_SLOTS  = 32;

	// shadow copy of the engine
	logic [15:0] seq_no;
	int          trans_ptr;
	int          rec_ptr;
	logic [7:0]  n_states;
	logic [6:0]  n_events;
	logic [6:0]  cur;
	logic [31:0] flags;
	logic [15:0] seq_latch;
	logic [15:0] type_latch;
	logic [7:0]  trans_mem [TRANS_SLOTS];
	logic [15:0] rec_mem [RECORD_SLOTS];

	tdfe_out_t expected_q [$];

	task automatic report(input string field, input logic [15:0] got, input logic [15:0] want);
		$display("tdfe_checker: %s mismatch, got %h expected %h", field, got, want);
		errors++;
	endtask

	function automatic logic [15:0] clamp(input logic [15:0] w, input logic [15:0] top);
		if (w[15])
			return 16'd0;
		return (w > top) ? top : w;
	endfunction

	task automatic clear_engine();
		seq_no = 16'd1;
		trans_ptr = 0;
		rec_ptr = 0;
		n_states = '0;
		n_events = '0;
		cur = '0;
		flags = '0;
		seq_latch = '0;
		type_latch = '0;
		foreach (trans_mem[i])
			trans_mem[i] = '0;
		foreach (rec_mem[i])
			rec_mem[i] = '0;
	endtask

	task automatic take_step();
		logic [7:0] next;
		int         slot;
		next = NO_TRANS;
		for (int i = 0; i < n_events; i++) begin
			if (flags[i]) begin
				slot = cur * n_events + i;
				if (slot < TRANS_SLOTS && trans_mem[slot] != NO_TRANS)
					next = trans_mem[slot];
			end
		end
		if (next != NO_TRANS)
			cur = next[6:0];
		flags = '0;
	endtask

	task automatic take_packet_word(input tdfe_in_t w, inout tdfe_out_t r);
		logic matched;
		if (w.word_index == IDX_SEQ) begin
			seq_latch = w.word_value;
			return;
		end
		if (w.word_index == IDX_TYPE) begin
			type_latch = w.word_value;
			return;
		end
		matched = (seq_latch == seq_no);
		if (matched && type_latch == TYPE_COUNTS) begin
			if (w.word_index == IDX_SCNT)
				n_states = 8'(clamp(w.word_value, 16'd255));
			if (w.word_index == IDX_ECNT)
				n_events = 7'(clamp(w.word_value, 16'(EVENT_SLOTS)));
		end else if (matched && type_latch == TYPE_TABLE) begin
			if (trans_ptr < TRANS_SLOTS) begin
				trans_mem[trans_ptr] = w.word_value[7:0];
				trans_ptr++;
			end
		end else if (matched && type_latch == TYPE_RECORDS) begin
			if (rec_ptr < RECORD_SLOTS) begin
				rec_mem[rec_ptr] = w.word_value;
				rec_ptr++;
			end
		end
		if (w.word_index == IDX_LAST) begin
			if (matched && type_latch >= TYPE_COUNTS && type_latch <= TYPE_RECORDS) begin
				r.packet_accepted = 1'b1;
				seq_no = seq_no + 16'd1;
			end else if (type_latch == TYPE_FINISH) begin
				cur = '0;
				flags = '0;
				r.load_done = 1'b1;
			end else if (type_latch == TYPE_START) begin
				r.start_pressed = 1'b1;
			end
		end
	endtask

	function automatic logic [15:0] rec_word(input int k);
		int a;
		a = cur * REC_WORDS + k;
		return (a < RECORD_SLOTS) ? rec_mem[a] : 16'd0;
	endfunction

	task automatic predict(input tdfe_in_t w, output tdfe_out_t r);
		r = '0;
		case (w.action)
			ACT_WORD:  take_packet_word(w, r);
			ACT_EVENT: flags[w.evt_no] = 1'b1;
			ACT_STEP:  take_step();
			ACT_INIT:  clear_engine();
			default:   ;
		endcase
		r.current_index = cur;
		r.rec_state_no  = rec_word(0);
		r.rec_action_no = rec_word(1);
		r.rec_value0    = rec_word(2);
		r.rec_value1    = rec_word(3);
		r.rec_value2    = rec_word(4);
		r.rec_value3    = rec_word(5);
	endtask

	task automatic compare(input tdfe_out_t got, input tdfe_out_t want);
		if (got.packet_accepted !== want.packet_accepted)
			report("packet_accepted", 16'(got.packet_accepted), 16'(want.packet_accepted));
		if (got.load_done !== want.load_done)
			report("load_done", 16'(got.load_done), 16'(want.load_done));
		if (got.start_pressed !== want.start_pressed)
			report("start_pressed", 16'(got.start_pressed), 16'(want.start_pressed));
		if (got.current_index !== want.current_index)
			report("current_index", 16'(got.current_index), 16'(want.current_index));
		if (got.rec_state_no !== want.rec_state_no)
			report("rec_state_no", got.rec_state_no, want.rec_state_no);
		if (got.rec_action_no !== want.rec_action_no)
			report("rec_action_no", got.rec_action_no, want.rec_action_no);
		if (got.rec_value0 !== want.rec_value0)
			report("rec_value0", got.rec_value0, want.rec_value0);
		if (got.rec_value1 !== want.rec_value1)
			report("rec_value1", got.rec_value1, want.rec_value1);
		if (got.rec_value2 !== want.rec_value2)
			report("rec_value2", got.rec_value2, want.rec_value2);
		if (got.rec_value3 !== want.rec_value3)
			report("rec_value3", got.rec_value3, want.rec_value3);
	endtask

	always @(posedge clk or negedge arst_n) begin
		tdfe_out_t r;
		if (!arst_n) begin
			clear_engine();
			expected_q.delete();
			errors = 0;
			pending <= 0;
		end else begin
			// response first: it belongs to an earlier command
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0)
					report("unexpected word", 16'(rsp_word.current_index), 16'd0);
				else
					compare(rsp_word, expected_q.pop_front());
			end
			if (req_valid && req_ready) begin
				predict(req_word, r);
				expected_q.push_back(r);
			end
			pending <= expected_q.size();
		end
	end
endmodule

[dv/testbench.sv]
// stimulus and verdict for the table driven fsm engine
// depends on tdfe_pkg, table_driven_fsm_engine_top and tdfe_checker
`timescale 1ns / 1ps
module testbench;
	import tdfe_pkg::*;

	// command codes the package does not name
	localparam logic [2:0] ACT_QUERY = 3'd4;
	localparam logic [2:0] ACT_RSVD  = 3'd5;
	// enough cycles for a full 32-event step to come out
	localparam int DRAIN_CYCLES = 80;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	tdfe_in_t   req_word = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	tdfe_out_t  rsp_word;
	int         errors;
	int         pending;

	// stimulus bookkeeping
	int          n_words;
	logic [15:0] seq_no;
	logic [15:0] pkt_data [14];
	bit          no_stall;
	int          stall_left;
	int          ready_roll;
	logic [3:0]  n_ev;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	table_driven_fsm_engine_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_word  (rsp_word)
	);

	tdfe_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_word  (rsp_word),
		.errors    (errors),
		.pending   (pending)
	);

	// receiver: mostly ready, short stalls, a few long ones
	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (no_stall) begin
			rsp_ready <= 1'b1;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 70) begin
				rsp_ready <= 1'b1;
			end else if (ready_roll < 95) begin
				rsp_ready <= 1'b0;
				stall_left <= $urandom_range(1, 3);
			end else begin
				rsp_ready <= 1'b0;
				stall_left <= $urandom_range(20, 60);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_stall || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// one command word; called at a rising edge, returns at the accepting edge
	task automatic put(input logic [2:0] act, input logic [3:0] idx, input logic [15:0] val,
		input logic [4:0] ev);
		int       gap;
		tdfe_in_t w;
		gap = pick_gap();
		w.action = act;
		w.word_index = idx;
		w.word_value = val;
		w.evt_no = ev;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_word <= w;
		// ready is settled by the falling edge
		do
			@(negedge clk);
		while (!req_ready);
		@(posedge clk);
		n_words++;
	endtask

	task automatic reinit();
		put(ACT_INIT, 4'($urandom), 16'($urandom), 5'($urandom));
		seq_no = 16'd1;
	endtask

	// packet from pkt_data; a short count leaves the packet broken off
	task automatic send_pkt(input logic [15:0] seq, input logic [15:0] typ, input int count);
		logic [15:0] v;
		for (int i = 0; i < count; i++) begin
			v = (i == 0) ? seq : (i == 1) ? typ : pkt_data[i - 2];
			put(ACT_WORD, 4'(i), v, 5'($urandom));
		end
		if (count == 16 && seq == seq_no && typ >= TYPE_COUNTS && typ <= TYPE_RECORDS)
			seq_no = seq_no + 16'd1;
	endtask

	task automatic fill_random();
		foreach (pkt_data[i])
			pkt_data[i] = 16'($urandom);
	endtask

	// well-formed program: counts, transition table, records, finish
	task automatic load_program(input int ns, input int ne);
		int n;
		int r;
		reinit();
		fill_random();
		pkt_data[0] = 16'(ns);
		pkt_data[1] = 16'(ne);
		send_pkt(seq_no, TYPE_COUNTS, 16);
		n = ns * ne;
		for (int base = 0; base < n; base += 14) begin
			fill_random();
			for (int j = 0; j < 14; j++) begin
				r = $urandom_range(0, 99);
				// upper byte is ignored by the table
				if (r < 25)
					pkt_data[j][7:0] = NO_TRANS;
				else if (r < 35)
					pkt_data[j][7:0] = {1'b1, 7'($urandom_range(0, ns - 1))};
				else
					pkt_data[j][7:0] = 8'($urandom_range(0, ns - 1));
			end
			send_pkt(seq_no, TYPE_TABLE, 16);
		end
		for (int base = 0; base < ns * 6; base += 14) begin
			fill_random();
			send_pkt(seq_no, TYPE_RECORDS, 16);
		end
		fill_random();
		send_pkt(16'($urandom), TYPE_FINISH, 16);
		n_ev = 4'(ne);
	endtask

	// sender holds off until every response is back
	task automatic drain();
		req_valid <= 1'b0;
		// let the count of the last accepted word settle
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_type();
		case ($urandom_range(0, 5))
			0: return TYPE_COUNTS;
			1: return TYPE_TABLE;
			2: return TYPE_RECORDS;
			3: return TYPE_START;
			4: return TYPE_FINISH;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int  r;
		int  stop_at;
		logic [15:0] s;
		n_words = 0;
		seq_no = 16'd1;
		no_stall = 1'b0;
		stall_left = 0;
		n_ev = 4'd1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: the write pointers are cleared first so every read is defined
		reinit();
		put(ACT_QUERY, 4'd0, 16'd0, 5'd0);
		put(ACT_RSVD, 4'hF, 16'hFFFF, 5'h1F);
		put(ACT_RSVD + 3'd2, 4'd0, 16'h8000, 5'd0);
		// negative counts become zero, large ones saturate
		fill_random();
		pkt_data[0] = 16'hFFFF;
		pkt_data[1] = 16'h8000;
		send_pkt(seq_no, TYPE_COUNTS, 16);
		pkt_data[0] = 16'd300;
		pkt_data[1] = 16'd100;
		send_pkt(seq_no, TYPE_COUNTS, 16);
		pkt_data[0] = 16'd4;
		pkt_data[1] = 16'd3;
		send_pkt(seq_no, TYPE_COUNTS, 16);
		// table: no-transition entries and a next state with bit 7 set
		foreach (pkt_data[i])
			pkt_data[i] = {8'($urandom), 8'(i % 4)};
		pkt_data[0] = 16'h00FF;
		pkt_data[1] = 16'h1285;
		pkt_data[2] = 16'hFFFF;
		send_pkt(seq_no, TYPE_TABLE, 16);
		foreach (pkt_data[i])
			pkt_data[i] = (i % 2) ? 16'h8000 : 16'h7FFF;
		send_pkt(seq_no, TYPE_RECORDS, 16);
		send_pkt(seq_no, TYPE_RECORDS, 16);
		// wrong sequence number is not taken
		send_pkt(seq_no + 16'd7, TYPE_RECORDS, 16);
		send_pkt(16'($urandom), TYPE_FINISH, 16);
		put(ACT_EVENT, 4'd0, 16'd0, 5'd0);
		put(ACT_EVENT, 4'd0, 16'd0, 5'd1);
		put(ACT_EVENT, 4'd0, 16'd0, 5'd31);
		put(ACT_STEP, 4'd0, 16'd0, 5'd0);
		put(ACT_EVENT, 4'd0, 16'd0, 5'd2);
		put(ACT_STEP, 4'd0, 16'd0, 5'd0);
		put(ACT_STEP, 4'd0, 16'd0, 5'd0);
		send_pkt(16'($urandom), TYPE_START, 16);
		drain();

		// random: mostly loaded programs driven by events and steps
		stop_at = n_words + 300;
		while (n_words < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				load_program($urandom_range(1, 8), $urandom_range(1, 8));
			end else if (r < 45) begin
				if ($urandom_range(0, 9) == 0)
					put(ACT_EVENT, 4'($urandom), 16'($urandom), 5'($urandom));
				else
					put(ACT_EVENT, 4'($urandom), 16'($urandom), 5'($urandom_range(0, n_ev)));
			end else if (r < 62) begin
				put(ACT_STEP, 4'($urandom), 16'($urandom), 5'($urandom));
			end else if (r < 68) begin
				put(ACT_QUERY + 3'($urandom_range(0, 3)), 4'($urandom), 16'($urandom),
					5'($urandom));
			end else if (r < 78) begin
				// noise and broken packets
				fill_random();
				s = ($urandom_range(0, 1) == 0) ? seq_no : 16'($urandom);
				send_pkt(s, pick_type(), ($urandom_range(0, 2) == 0) ?
					$urandom_range(1, 15) : 16);
			end else if (r < 84) begin
				put(ACT_WORD, 4'($urandom), 16'($urandom), 5'($urandom));
			end else if (r < 86) begin
				reinit();
			end else if (r < 88) begin
				no_stall = !no_stall;
			end else begin
				repeat ($urandom_range(1, 4))
					put(ACT_EVENT, 4'($urandom), 16'($urandom), 5'($urandom_range(0, n_ev)));
				put(ACT_STEP, 4'($urandom), 16'($urandom), 5'($urandom));
			end
		end

		no_stall = 1'b0;
		drain();
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// run limit, far beyond the slowest correct run
	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/tdfe_pkg.sv
rtl/core/tdfe_ram.sv
rtl/core/table_driven_fsm_engine_top.sv
dv/tdfe_checker.sv
dv/testbench.sv
